// ----- src/wbss_pkg.sv -----
package wbss_pkg;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       end_of_image;
   } wbss_req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] match_address;
   } wbss_rsp_type;

   typedef struct packed {
      logic [63:0] pattern_low_bytes;
      logic [63:0] pattern_high_bytes;
      logic [15:0] care_mask;
      logic [4:0]  pattern_length;
   } wbss_scan_cfg_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int SIG_BYTES = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARE_MASK    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_BASE   = 3'd4;

endpackage

// ----- src/wbss_front.sv -----
module wbss_front #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wbss_pkg::wbss_scan_cfg_type cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  wbss_pkg::wbss_req_type     req_payload,
   input  logic                       queue_full,
   output logic                       push_valid,
   output logic                       push_found,
   output logic [OFFSET_BITS-1:0]     push_offset
);
   import wbss_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

   logic [7:0]                   window_ff [MAX_PATTERN_BYTES];
   logic [7:0]                   window_in [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0]       bytes_seen_ff;
   logic [OFFSET_BITS-1:0]       bytes_seen_in;
   logic [OFFSET_BITS-1:0]       count_inc;
   logic                         found_ff;
   logic                         found_in;
   logic [LW-1:0]                active_len;
   logic [7:0]                   sig_bytes [SIG_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] lane_ok;
   logic                         hit;
   logic                         accept;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      if (32'(cfg.pattern_length) > 32'(MAX_PATTERN_BYTES)) begin
         active_len = LW'(MAX_PATTERN_BYTES);
      end else if (cfg.pattern_length == 5'd0) begin
         active_len = LW'(1);
      end else begin
         active_len = LW'(cfg.pattern_length);
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sig_bytes[i]     = cfg.pattern_low_bytes[8*i +: 8];
         sig_bytes[i + 8] = cfg.pattern_high_bytes[8*i +: 8];
      end
   end

   always_comb begin
      window_in[0] = req_payload.image_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   always_comb begin
      if (bytes_seen_ff == {OFFSET_BITS{1'b1}}) begin
         count_inc = bytes_seen_ff;
      end else begin
         count_inc = bytes_seen_ff + OFFSET_BITS'(1);
      end
   end

   // Window entry j holds signature byte (length - 1 - j) of a candidate match.
   always_comb begin
      int k;
      k = 0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         lane_ok[j] = 1'b1;
         if (j < int'(active_len)) begin
            k = int'(active_len) - 1 - j;
            if (k < SIG_BYTES) begin
               if (cfg.care_mask[k[3:0]] && (sig_bytes[k[3:0]] != window_in[j])) begin
                  lane_ok[j] = 1'b0;
               end
            end
         end
      end
   end

   assign hit = (count_inc >= OFFSET_BITS'(active_len)) && (&lane_ok);

   assign push_valid  = accept && !found_ff && (hit || req_payload.end_of_image);
   assign push_found  = hit;
   assign push_offset = hit ? (count_inc - OFFSET_BITS'(active_len)) : '0;

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      found_in      = found_ff;
      if (accept) begin
         if (req_payload.end_of_image) begin
            bytes_seen_in = '0;
            found_in      = 1'b0;
         end else if (!found_ff) begin
            bytes_seen_in = count_inc;
            found_in      = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         found_ff      <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !found_ff) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- src/wbss_queue.sv -----
module wbss_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = 4;
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [PW:0]      count_ff;
   logic [PW:0]      count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/wbss_back.sv -----
module wbss_back #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [63:0]            image_base,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic                   pop_found,
   input  logic [OFFSET_BITS-1:0] pop_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wbss_pkg::wbss_rsp_type rsp_payload
);
   import wbss_pkg::*;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   wbss_rsp_type rsp_payload_ff;
   wbss_rsp_type rsp_payload_in;
   logic         load;

   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_payload_in.found = pop_found;
         if (pop_found) begin
            rsp_payload_in.match_address = image_base + 64'(pop_offset);
         end else begin
            rsp_payload_in.match_address = '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- src/wildcard_byte_signature_scan_top.sv -----
// Scans a memory image streamed one byte per request, in address order, for a
// signature of up to MAX_PATTERN_BYTES bytes with per-byte wildcards, and reports
// image_base plus the start offset of the first match, or a not-found result when
// the byte marked end_of_image arrives without a match. The block takes one byte
// every clock cycle while the queue is not full (req_stall is low), since the whole
// window is compared against the signature in parallel in the cycle the byte is
// accepted; a result reaches the response port through a four-entry queue and the
// address adder and register in the output stage. Configuration writes are always
// accepted and are meant to be made between images.
module wildcard_byte_signature_scan_top #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wbss_pkg::wbss_req_type                 req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wbss_pkg::wbss_rsp_type                 rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbss_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [63:0]                            csr_wdata
);
   import wbss_pkg::*;

   wbss_scan_cfg_type      cfg_ff;
   wbss_scan_cfg_type      cfg_in;
   logic [63:0]            image_base_ff;
   logic [63:0]            image_base_in;
   logic                   push_valid;
   logic                   push_found;
   logic [OFFSET_BITS-1:0] push_offset;
   logic                   queue_full;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [OFFSET_BITS:0]   pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in        = cfg_ff;
      image_base_in = image_base_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  cfg_in.pattern_low_bytes  = csr_wdata;
            CSR_PATTERN_HIGH: cfg_in.pattern_high_bytes = csr_wdata;
            CSR_CARE_MASK:    cfg_in.care_mask          = csr_wdata[15:0];
            CSR_PATTERN_LEN:  cfg_in.pattern_length     = csr_wdata[4:0];
            CSR_IMAGE_BASE:   image_base_in             = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_bytes  <= '0;
         cfg_ff.pattern_high_bytes <= '0;
         cfg_ff.care_mask          <= '0;
         cfg_ff.pattern_length     <= 5'd1;
         image_base_ff             <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         image_base_ff <= image_base_in;
      end
   end

   wbss_front #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_found(push_found),
      .push_offset(push_offset)
   );

   wbss_queue #(
      .WIDTH(OFFSET_BITS + 1)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data({push_found, push_offset}),
      .full(queue_full),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   wbss_back #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .image_base(image_base_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_found(pop_data[OFFSET_BITS]),
      .pop_offset(pop_data[OFFSET_BITS-1:0]),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
